// File: rtl/core/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants for the IR marker corner sorter.
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int NumSlots = 4;
    localparam int SlotW    = 2;
    localparam int CamXW    = 13;
    localparam int CamYW    = 10;
    localparam int ResW     = 12;

    localparam logic [ResW-1:0] RES_WIDTH_RESET = 12'd1024;

    // corner slot codes
    localparam logic [SlotW-1:0] SLOT_BL = 2'd0;
    localparam logic [SlotW-1:0] SLOT_TL = 2'd1;
    localparam logic [SlotW-1:0] SLOT_TR = 2'd2;
    localparam logic [SlotW-1:0] SLOT_BR = 2'd3;

    // one frame's worth of results, queued between front and back
    typedef struct packed {
        logic                                locked;
        logic [NumSlots-1:0]                 valid;
        logic [NumSlots-1:0][CamYW-1:0]      cam_y;
        logic [NumSlots-1:0][CamXW-1:0]      cam_x;
    } frame_rec_t;

endpackage

// File: rtl/core/ims_front.sv
// ----------------------------------------------------------------------------
// ims_front
// Frame intake: corner sort, order lock, X mirroring and held-value update.
// ----------------------------------------------------------------------------
module ims_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [8*COORD_BITS-1:0]       in_data,
    input  logic [ims_pkg::ResW-1:0]      res_width,
    output ims_pkg::frame_rec_t           rec
);
    import ims_pkg::*;

    localparam logic [COORD_BITS-1:0] MissingCode = '1;

    logic [NumSlots-1:0][COORD_BITS-1:0] px;
    logic [NumSlots-1:0][COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0]               hx, sx, hy, sy;
    logic [NumSlots-1:0]                 is_left, is_bottom;
    logic                                all_present;
    logic                                dup_found;

    logic [NumSlots-1:0][SlotW-1:0]      sorted;
    logic [NumSlots-1:0][SlotW-1:0]      corner_order_reg, corner_order_next;
    logic                                needs_sort_reg, needs_sort_next;
    logic [NumSlots-1:0][CamXW-1:0]      held_x_reg, held_x_next;
    logic [NumSlots-1:0][CamYW-1:0]      held_y_reg, held_y_next;
    logic [NumSlots-1:0]                 valid_v;

    always_comb
    begin
        all_present = 1'b1;
        for (int i = 0; i < NumSlots; i++)
        begin
            px[i] = in_data[(2*i)*COORD_BITS +: COORD_BITS];
            py[i] = in_data[(2*i+1)*COORD_BITS +: COORD_BITS];
            if (px[i] == MissingCode || py[i] == MissingCode)
            begin
                all_present = 1'b0;
            end
        end
    end

    // running top-two of X and Y; a tie does not displace the second
    always_comb
    begin
        hx = '0; sx = '0; hy = '0; sy = '0;
        for (int i = 0; i < NumSlots; i++)
        begin
            if (px[i] > sx)
            begin
                if (px[i] > hx)
                begin
                    sx = hx;
                    hx = px[i];
                end
                else
                begin
                    sx = px[i];
                end
            end
            if (py[i] > sy)
            begin
                if (py[i] > hy)
                begin
                    sy = hy;
                    hy = py[i];
                end
                else
                begin
                    sy = py[i];
                end
            end
        end
    end

    // labels; a slot nobody claims keeps its old point index
    always_comb
    begin
        sorted = corner_order_reg;
        for (int i = 0; i < NumSlots; i++)
        begin
            is_left[i]   = (px[i] >= sx);
            is_bottom[i] = (py[i] >= sy);
            if (is_left[i])
            begin
                if (is_bottom[i])
                begin
                    sorted[SLOT_BL] = SlotW'(i);
                end
                else
                begin
                    sorted[SLOT_TL] = SlotW'(i);
                end
            end
            else
            begin
                if (is_bottom[i])
                begin
                    sorted[SLOT_BR] = SlotW'(i);
                end
                else
                begin
                    sorted[SLOT_TR] = SlotW'(i);
                end
            end
        end
        dup_found = 1'b0;
        for (int i = 0; i < NumSlots; i++)
        begin
            for (int j = i + 1; j < NumSlots; j++)
            begin
                if (sorted[i] == sorted[j])
                begin
                    dup_found = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        corner_order_next = corner_order_reg;
        needs_sort_next   = needs_sort_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        valid_v           = '0;
        if (all_present)
        begin
            if (needs_sort_reg)
            begin
                corner_order_next = sorted;
                needs_sort_next   = dup_found;
            end
            for (int i = 0; i < NumSlots; i++)
            begin
                held_x_next[i] = CamXW'({1'b0, res_width})
                               - CamXW'(px[corner_order_next[i]]);
                held_y_next[i] = CamYW'(py[corner_order_next[i]]);
                valid_v[i]     = 1'b1;
            end
        end
        else
        begin
            needs_sort_next = 1'b1;
            // raw order; only X decides whether a point is missing here
            for (int i = 0; i < NumSlots; i++)
            begin
                if (px[i] != MissingCode)
                begin
                    held_x_next[i] = CamXW'({1'b0, res_width}) - CamXW'(px[i]);
                    held_y_next[i] = CamYW'(py[i]);
                    valid_v[i]     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumSlots; i++)
            begin
                corner_order_reg[i] <= SlotW'(i);
            end
            needs_sort_reg <= 1'b1;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
        end
        else if (push)
        begin
            corner_order_reg <= corner_order_next;
            needs_sort_reg   <= needs_sort_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
        end
    end

    assign rec.locked = ~needs_sort_next;
    assign rec.valid  = valid_v;
    assign rec.cam_x  = held_x_next;
    assign rec.cam_y  = held_y_next;

endmodule

// File: rtl/core/ims_fifo.sv
// ----------------------------------------------------------------------------
// ims_fifo
// Small register queue carrying frame records from front to back.
// ----------------------------------------------------------------------------
module ims_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == DepthCnt);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/ims_back.sv
// ----------------------------------------------------------------------------
// ims_back
// Serializes one frame record into four slot results with an output register.
// ----------------------------------------------------------------------------
module ims_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ims_pkg::frame_rec_t           q_data,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ims_pkg::SlotW-1:0]     out_slot,
    output logic [ims_pkg::CamXW-1:0]     out_cam_x,
    output logic [ims_pkg::CamYW-1:0]     out_cam_y,
    output logic                          out_point_valid,
    output logic                          out_locked,
    output logic                          out_last
);
    import ims_pkg::*;

    frame_rec_t         cur_reg;
    logic               cur_valid_reg;
    logic [SlotW-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [SlotW-1:0]   slot_reg;
    logic [CamXW-1:0]   cam_x_reg;
    logic [CamYW-1:0]   cam_y_reg;
    logic               pv_reg, locked_reg, last_reg;
    logic               load_out, frame_done;

    assign load_out   = cur_valid_reg && (!out_valid_reg || out_ready);
    assign frame_done = load_out && (idx_reg == SLOT_BR);
    assign q_pop      = !q_empty && (!cur_valid_reg || frame_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= SLOT_BL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (frame_done)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (load_out)
        begin
            slot_reg   <= idx_reg;
            cam_x_reg  <= cur_reg.cam_x[idx_reg];
            cam_y_reg  <= cur_reg.cam_y[idx_reg];
            pv_reg     <= cur_reg.valid[idx_reg];
            locked_reg <= cur_reg.locked;
            last_reg   <= (idx_reg == SLOT_BR);
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_slot        = slot_reg;
    assign out_cam_x       = cam_x_reg;
    assign out_cam_y       = cam_y_reg;
    assign out_point_valid = pv_reg;
    assign out_locked      = locked_reg;
    assign out_last        = last_reg;

endmodule

// File: rtl/core/ir_marker_corner_sorter.sv
// ----------------------------------------------------------------------------
// ir_marker_corner_sorter
// Sorts four IR marker points into corner slots and streams them out mirrored.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata: 4 points, X then Y each
//  m_*       out  m_tvalid / m_tready    m_tdata, m_tuser, m_tlast
//  cfg_*     in   cfg_wr_en              cfg_wr_data: res_width
//
//  Each frame item is classified in the cycle it is accepted (front) and
//  queued as one record; the back emits the four slot results one per cycle
//  while m_tready allows, so sustained throughput is set by the output serializer.
//  From accept to first result a frame passes the record queue, current record reg and output reg.
//  A two-entry record queue lets the front keep accepting, until full, while m_tready is low.
//  Reset: order identity, sort pending, held coordinates zero, res_width 1024.
// ----------------------------------------------------------------------------
module ir_marker_corner_sorter #(
    parameter int COORD_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // point1_x, point1_y, point2_x, point2_y, ..., point4_y (COORD_BITS each)
    input  logic [8*COORD_BITS-1:0]       s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cam_x[12:0] (signed), cam_y[22:13], zero pad [23]
    output logic [23:0]                   m_tdata,
    // slot[1:0], point_valid[2], order_locked[3]
    output logic [3:0]                    m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic [ims_pkg::ResW-1:0]      cfg_wr_data
);
    import ims_pkg::*;

    localparam int RecW = $bits(frame_rec_t);

    logic [ResW-1:0]  res_width_reg;
    frame_rec_t       front_rec;
    frame_rec_t       q_data;
    logic             q_full, q_empty, q_pop, push;
    logic [SlotW-1:0] slot;
    logic [CamXW-1:0] cam_x;
    logic [CamYW-1:0] cam_y;
    logic             point_valid, order_locked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_width_reg <= RES_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            res_width_reg <= cfg_wr_data;
        end
    end

    assign s_tready = ~q_full;
    assign push     = s_tvalid & ~q_full;

    ims_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_data   (s_tdata),
        .res_width (res_width_reg),
        .rec       (front_rec)
    );

    ims_fifo #(
        .WIDTH (RecW),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_rec),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ims_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_data          (q_data),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_slot        (slot),
        .out_cam_x       (cam_x),
        .out_cam_y       (cam_y),
        .out_point_valid (point_valid),
        .out_locked      (order_locked),
        .out_last        (m_tlast)
    );

    assign m_tdata = {1'b0, cam_y, cam_x};
    assign m_tuser = {order_locked, point_valid, slot};

endmodule
